>>> rtl/osm_pkg.sv
// Shared types and constants of the order-statistic multiset.
package osm_pkg;

  localparam int unsigned CAPACITY_DEF = 1024;
  localparam int unsigned KEY_W = 32;
  localparam int unsigned POS_W = 11;
  localparam int unsigned REQ_W = 3;
  localparam int unsigned STAT_W = 2;

  typedef enum logic [REQ_W-1:0] {
    REQ_INSERT = 3'd0,
    REQ_DELETE = 3'd1,
    REQ_RANK   = 3'd2,
    REQ_KTH    = 3'd3,
    REQ_PRED   = 3'd4,
    REQ_SUCC   = 3'd5
  } req_t;

  localparam logic [STAT_W-1:0] ST_OK = 2'd0;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_SWAIT,
    S_FETCH,
    S_FWAIT,
    S_SHIFT,
    S_DONE
  } state_t;

endpackage

>>> rtl/osm_if.sv
// Valid/ready channel interfaces of the order-statistic multiset.
interface osm_req_if;
  import osm_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [REQ_W-1:0]        req_type;
  logic signed [KEY_W-1:0] key;
  logic [POS_W-1:0]        position;
  modport source (output valid, req_type, key, position, input ready);
  modport sink (input valid, req_type, key, position, output ready);
endinterface

interface osm_rsp_if;
  import osm_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [KEY_W-1:0] result_key;
  logic [POS_W-1:0]        result_rank;
  logic [STAT_W-1:0]       status;
  modport source (output valid, result_key, result_rank, status, input ready);
  modport sink (input valid, result_key, result_rank, status, output ready);
endinterface

>>> rtl/osm_ram.sv
// Generic single-port RAM with a registered read.
module osm_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

>>> rtl/order_statistic_multiset.sv
// Top level of the order-statistic multiset over a sorted key store.
//
//  channel  dir  payload
//  req      in   req_type, key, position
//  rsp      out  result_key, result_rank, status
//
// A request is taken in the idle state. The binary search then alternates a
// search state, which addresses the middle entry, and a wait state, which uses
// the registered read, and ends in a closing search state; kth skips it. Kth,
// predecessor, successor and delete then read one entry through a fetch and a
// wait state. Insert moves the tail up and delete moves it down, one RAM access
// a cycle. The result waits in the done state, so a stalled result holds the
// block. Reset clears the state and, of the data, only the entry count.
module order_statistic_multiset
  import osm_pkg::*;
#(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input logic       clk,
  input logic       rst,
  osm_req_if.sink   req,
  osm_rsp_if.source rsp
);
  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  state_t state, state_next;
  logic [CW-1:0] count;
  logic [CW-1:0] lo, hi, mid;
  logic [CW-1:0] ptr;
  logic phase;
  logic [REQ_W-1:0] rq;
  logic signed [KEY_W-1:0] rkey;
  logic signed [KEY_W-1:0] carry;
  logic signed [KEY_W-1:0] out_key;
  logic [POS_W-1:0] out_rank;
  logic [STAT_W-1:0] out_stat;

  logic we;
  logic [AW-1:0] addr;
  logic [KEY_W-1:0] wdata, rdata;
  logic signed [KEY_W-1:0] rd_s;
  logic go_right;
  logic not_above;
  logic req_full;
  logic pos_ok;
  logic del_last;

  osm_ram #(.WIDTH(KEY_W), .DEPTH(CAPACITY)) u_ram (
    .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
  );
  assign rd_s = rdata;
  assign mid = lo + ((hi - lo) >> 1);

  // Insert and successor search on "<=", the rest on "<".
  assign not_above = (rq == REQ_INSERT) || (rq == REQ_SUCC);
  assign go_right = not_above ? (rd_s <= rkey) : (rd_s < rkey);

  assign req_full = (count >= CW'(CAPACITY));
  assign pos_ok = (req.position != '0) && (32'(req.position) <= 32'(count));
  assign del_last = (32'(ptr) + 32'd1 >= 32'(count));

  assign req.ready = (state == S_IDLE);
  assign rsp.valid = (state == S_DONE);
  assign rsp.result_key = out_key;
  assign rsp.result_rank = out_rank;
  assign rsp.status = out_stat;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req.valid) begin
          if (req.req_type > REQ_SUCC) state_next = S_DONE;
          else if (req.req_type == REQ_KTH) state_next = pos_ok ? S_FETCH : S_DONE;
          else if (req.req_type == REQ_INSERT && req_full) state_next = S_DONE;
          else state_next = S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (lo < hi) state_next = S_SWAIT;
        else begin
          case (rq)
            REQ_INSERT: state_next = S_SHIFT;
            REQ_DELETE: state_next = (lo < count) ? S_FETCH : S_DONE;
            REQ_PRED: state_next = (lo != '0) ? S_FETCH : S_DONE;
            REQ_SUCC: state_next = (lo < count) ? S_FETCH : S_DONE;
            default: state_next = S_DONE;
          endcase
        end
      end
      S_SWAIT: state_next = S_SEARCH;
      S_FETCH: state_next = S_FWAIT;
      S_FWAIT: begin
        if (rq == REQ_DELETE && rd_s == rkey) state_next = S_SHIFT;
        else state_next = S_DONE;
      end
      S_SHIFT: begin
        if (rq == REQ_INSERT) begin
          if (phase && ptr == count) state_next = S_DONE;
        end else if (!phase && del_last) state_next = S_DONE;
      end
      S_DONE: if (rsp.ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // In the shift, phase 0 reads an entry and phase 1 writes one.
  always_comb begin
    we = 1'b0;
    wdata = carry;
    addr = mid[AW-1:0];
    case (state)
      S_FETCH: addr = ptr[AW-1:0];
      S_SHIFT: begin
        if (rq == REQ_INSERT) begin
          addr = ptr[AW-1:0];
          we = phase;
        end else begin
          addr = phase ? ptr[AW-1:0] : AW'(ptr + CW'(1));
          we = phase;
          wdata = rd_s;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            rq <= req.req_type;
            rkey <= req.key;
            lo <= '0;
            hi <= count;
            ptr <= CW'(32'(req.position) - 32'd1);
            phase <= 1'b0;
            out_key <= '0;
            out_rank <= '0;
            if (req.req_type > REQ_SUCC) out_stat <= ST_NOT_FOUND;
            else if (req.req_type == REQ_INSERT && req_full) out_stat <= ST_FULL;
            else if (req.req_type == REQ_KTH && !pos_ok) out_stat <= ST_NOT_FOUND;
            else out_stat <= ST_OK;
          end
        end
        S_SWAIT: begin
          if (go_right) lo <= mid + CW'(1);
          else hi <= mid;
        end
        S_SEARCH: begin
          if (!(lo < hi)) begin
            carry <= rkey;
            case (rq)
              REQ_INSERT: ptr <= lo;
              REQ_DELETE: begin
                ptr <= lo;
                if (!(lo < count)) out_stat <= ST_NOT_FOUND;
              end
              REQ_RANK: out_rank <= POS_W'(32'(lo) + 32'd1);
              REQ_PRED: begin
                ptr <= lo - CW'(1);
                if (lo == '0) out_stat <= ST_NOT_FOUND;
              end
              REQ_SUCC: begin
                ptr <= lo;
                if (!(lo < count)) out_stat <= ST_NOT_FOUND;
              end
              default: ;
            endcase
          end
        end
        S_FWAIT: begin
          if (rq == REQ_DELETE) begin
            if (rd_s != rkey) out_stat <= ST_NOT_FOUND;
          end else out_key <= rd_s;
        end
        S_SHIFT: begin
          phase <= !phase;
          if (rq == REQ_INSERT) begin
            // Each write stores the carried key and picks up the old entry.
            if (phase) begin
              carry <= rd_s;
              ptr <= ptr + CW'(1);
              if (ptr == count) count <= count + CW'(1);
            end
          end else begin
            if (phase) ptr <= ptr + CW'(1);
            else if (del_last) count <= count - CW'(1);
          end
        end
        default: ;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_count: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY)) else $error("count above capacity");
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !(req.ready && rsp.valid)) else $error("ready while result pending");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.ready |=> rsp.valid && $stable({out_key, out_rank, out_stat}))
    else $error("result changed while stalled");
`endif
endmodule
